FILE: rtl/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;
    localparam int SLOTS_DEF  = 10;
    localparam int LEVELS_DEF = 4;
    localparam int TBITS_DEF  = 32;
    localparam int ID_W       = 4;
    localparam int LVL_W      = 2;
    localparam int PER_W      = 32;
    localparam int MAP_W      = 10;

    typedef enum logic [3:0] {
        CMD_TICK     = 4'd0,
        CMD_ADD      = 4'd1,
        CMD_REMOVE   = 4'd2,
        CMD_SUSPEND  = 4'd3,
        CMD_RESUME   = 4'd4,
        CMD_SET_PER  = 4'd5,
        CMD_SET_PRI  = 4'd6,
        CMD_DISPATCH = 4'd7,
        CMD_COMPLETE = 4'd8
    } cmd_t;

    localparam logic [1:0] ST_READY     = 2'd0;
    localparam logic [1:0] ST_RUNNING   = 2'd1;
    localparam logic [1:0] ST_SUSPENDED = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NONE  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request
        logic scan;    // visit slot at scan index
        logic finish;  // apply command at end of scan
    } pts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;    // scan index at last slot
    } pts_stat_t;
endpackage

FILE: rtl/pts_ctrl.sv
`timescale 1ns / 1ps
module pts_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  pts_pkg::pts_stat_t  stat,
    output pts_pkg::pts_cmd_t   ctl
);
    import pts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_SCAN;
            S_SCAN:   if (stat.last) state_next = S_FINISH;
            S_FINISH: state_next = S_OUT;
            S_OUT:    if (m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = (state_reg == S_OUT);
    assign ctl.load   = s_valid && s_ready;
    assign ctl.scan   = (state_reg == S_SCAN);
    assign ctl.finish = (state_reg == S_FINISH);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.scan |-> !s_ready) else $error("accept during scan");
    a_finish_once: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.finish |=> m_valid) else $error("finish without result");
endmodule

FILE: rtl/pts_dp.sv
`timescale 1ns / 1ps
module pts_dp #(
    parameter int NUM_SLOTS  = pts_pkg::SLOTS_DEF,
    parameter int NUM_LEVELS = pts_pkg::LEVELS_DEF,
    parameter int TIME_BITS  = pts_pkg::TBITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pts_pkg::pts_cmd_t         ctl,
    output pts_pkg::pts_stat_t        stat,
    input  logic [3:0]                s_cmd,
    input  logic [pts_pkg::ID_W-1:0]  s_slot_id,
    input  logic [pts_pkg::PER_W-1:0] s_period,
    input  logic [pts_pkg::LVL_W-1:0] s_level,
    output logic [1:0]                m_status,
    output logic [pts_pkg::ID_W-1:0]  m_chosen_slot,
    output logic [pts_pkg::MAP_W-1:0] m_due_map,
    output logic [pts_pkg::MAP_W-1:0] m_live_map,
    output logic [pts_pkg::PER_W-1:0] m_longest_run,
    output logic [pts_pkg::PER_W-1:0] m_now_time
);
    import pts_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TW = TIME_BITS;

    logic [TW-1:0]    period_mem   [NUM_SLOTS];
    logic [TW-1:0]    anchor_mem   [NUM_SLOTS];
    logic [TW-1:0]    longest_mem  [NUM_SLOTS];
    logic [TW-1:0]    disp_mem     [NUM_SLOTS];
    logic [LVL_W-1:0] level_mem    [NUM_SLOTS];
    logic [1:0]       run_mem      [NUM_SLOTS];

    logic [TW-1:0]        now_reg;
    logic [NUM_SLOTS-1:0] due_reg, live_reg;
    logic [3:0]           cmd_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TW-1:0]        per_reg;
    logic [LVL_W-1:0]     lvl_reg;
    logic [IW-1:0]        idx_reg;
    logic                 found_reg;
    logic [IW-1:0]        best_reg;
    logic [LVL_W-1:0]     best_lvl_reg;
    logic [1:0]           status_reg;
    logic [ID_W-1:0]      chosen_reg;
    logic [PER_W-1:0]     longest_out_reg;

    logic          in_range;
    logic [IW-1:0] tgt;
    logic [TW-1:0] elapsed, run_len, new_long;
    logic          elig;
    logic          addr_cmd;

    assign stat.last = (idx_reg == IW'(NUM_SLOTS - 1));
    assign in_range  = ({28'd0, id_reg} < 32'(NUM_SLOTS));
    assign tgt       = IW'(id_reg);
    assign elapsed   = now_reg - anchor_mem[idx_reg];
    assign elig      = due_reg[idx_reg] && live_reg[idx_reg] && run_mem[idx_reg] == ST_READY
                       && ({30'd0, level_mem[idx_reg]} < 32'(NUM_LEVELS));
    assign run_len   = now_reg - disp_mem[tgt];
    assign new_long  = (run_len > longest_mem[tgt]) ? run_len : longest_mem[tgt];
    assign addr_cmd  = cmd_reg >= CMD_REMOVE && cmd_reg <= CMD_COMPLETE
                       && cmd_reg != CMD_DISPATCH;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg   <= '0;
            due_reg   <= '0;
            live_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else if (ctl.load) begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            if (s_cmd == CMD_TICK) now_reg <= now_reg + 1'b1;
        end else if (ctl.scan) begin
            if (!stat.last) idx_reg <= idx_reg + 1'b1;
            case (cmd_reg)
                CMD_TICK:
                    if (live_reg[idx_reg] && run_mem[idx_reg] == ST_READY
                        && elapsed >= period_mem[idx_reg])
                        due_reg[idx_reg] <= 1'b1;
                CMD_ADD:
                    if (!found_reg && !live_reg[idx_reg]) found_reg <= 1'b1;
                CMD_DISPATCH:
                    if (elig && (!found_reg || level_mem[idx_reg] < best_lvl_reg))
                        found_reg <= 1'b1;
                default: ;
            endcase
        end else if (ctl.finish) begin
            if (cmd_reg == CMD_ADD && found_reg) live_reg[best_reg] <= 1'b1;
            if (cmd_reg == CMD_DISPATCH && found_reg) due_reg[best_reg] <= 1'b0;
            if (addr_cmd && in_range) begin
                if (cmd_reg == CMD_REMOVE) begin
                    live_reg[tgt] <= 1'b0;
                    due_reg[tgt]  <= 1'b0;
                end
                if (cmd_reg == CMD_SUSPEND) due_reg[tgt] <= 1'b0;
            end
        end
    end

    // payload and slot table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                period_mem[i]  <= '0;
                anchor_mem[i]  <= '0;
                longest_mem[i] <= '0;
                level_mem[i]   <= '0;
                run_mem[i]     <= ST_READY;
            end
        end else if (ctl.load) begin
            cmd_reg <= s_cmd;
            id_reg  <= s_slot_id;
            per_reg <= TW'(s_period);
            lvl_reg <= s_level;
        end else if (ctl.scan) begin
            case (cmd_reg)
                CMD_ADD:
                    if (!found_reg && !live_reg[idx_reg]) best_reg <= idx_reg;
                CMD_DISPATCH:
                    if (elig && (!found_reg || level_mem[idx_reg] < best_lvl_reg)) begin
                        best_reg     <= idx_reg;
                        best_lvl_reg <= level_mem[idx_reg];
                    end
                default: ;
            endcase
        end else if (ctl.finish) begin
            if (cmd_reg == CMD_ADD) begin
                longest_out_reg <= '0;
                if (found_reg) begin
                    period_mem[best_reg]  <= per_reg;
                    anchor_mem[best_reg]  <= now_reg;
                    longest_mem[best_reg] <= '0;
                    run_mem[best_reg]     <= ST_READY;
                    level_mem[best_reg]   <= lvl_reg;
                    status_reg            <= STAT_OK;
                    chosen_reg            <= ID_W'(best_reg);
                end else begin
                    status_reg <= STAT_NONE;
                    chosen_reg <= '0;
                end
            end else if (cmd_reg == CMD_DISPATCH) begin
                longest_out_reg <= '0;
                if (found_reg) begin
                    run_mem[best_reg]  <= ST_RUNNING;
                    disp_mem[best_reg] <= now_reg;
                    status_reg         <= STAT_OK;
                    chosen_reg         <= ID_W'(best_reg);
                end else begin
                    status_reg <= STAT_NONE;
                    chosen_reg <= '0;
                end
            end else if (addr_cmd) begin
                chosen_reg <= '0;
                if (!in_range) begin
                    status_reg      <= STAT_RANGE;
                    longest_out_reg <= '0;
                end else begin
                    status_reg      <= STAT_OK;
                    longest_out_reg <= (cmd_reg == CMD_COMPLETE) ? PER_W'(new_long) : '0;
                    case (cmd_reg)
                        CMD_REMOVE, CMD_SUSPEND: run_mem[tgt] <= ST_SUSPENDED;
                        CMD_RESUME: begin
                            run_mem[tgt]    <= ST_READY;
                            anchor_mem[tgt] <= now_reg;
                        end
                        CMD_SET_PER: begin
                            period_mem[tgt] <= per_reg;
                            anchor_mem[tgt] <= now_reg;
                        end
                        CMD_SET_PRI: level_mem[tgt] <= lvl_reg;
                        CMD_COMPLETE: begin
                            longest_mem[tgt] <= new_long;
                            anchor_mem[tgt]  <= now_reg;
                            run_mem[tgt]     <= ST_READY;
                        end
                        default: ;
                    endcase
                end
            end else begin
                status_reg      <= STAT_OK;
                chosen_reg      <= '0;
                longest_out_reg <= '0;
            end
        end
    end

    assign m_status      = status_reg;
    assign m_chosen_slot = chosen_reg;
    assign m_due_map     = MAP_W'(due_reg);
    assign m_live_map    = MAP_W'(live_reg);
    assign m_longest_run = longest_out_reg;
    assign m_now_time    = PER_W'(now_reg);
endmodule

FILE: rtl/periodic_task_scheduler_unit.sv
`timescale 1ns / 1ps
// Periodic task scheduler: a table of NUM_SLOTS task slots driven by one
// request per command (tick, add, remove, suspend, resume, set period, set
// priority, dispatch, complete). Every request walks the slot table one slot
// per cycle: it is captured, every slot is scanned, the command is applied,
// and the result is presented until it is accepted. The next request is
// taken once the result has been accepted.
module periodic_task_scheduler_unit #(
    parameter int NUM_SLOTS  = pts_pkg::SLOTS_DEF,
    parameter int NUM_LEVELS = pts_pkg::LEVELS_DEF,
    parameter int TIME_BITS  = pts_pkg::TBITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [3:0]                s_cmd,
    input  logic [pts_pkg::ID_W-1:0]  s_slot_id,
    input  logic [pts_pkg::PER_W-1:0] s_period,
    input  logic [pts_pkg::LVL_W-1:0] s_level,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [pts_pkg::ID_W-1:0]  m_chosen_slot,
    output logic [pts_pkg::MAP_W-1:0] m_due_map,
    output logic [pts_pkg::MAP_W-1:0] m_live_map,
    output logic [pts_pkg::PER_W-1:0] m_longest_run,
    output logic [pts_pkg::PER_W-1:0] m_now_time
);
    import pts_pkg::*;

    // command and status between the sequencer and the slot table
    pts_cmd_t  ctl;
    pts_stat_t stat;

    // sequencer: capture, scan, apply, present
    pts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // slot table, clock, due and live masks, result registers
    pts_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_LEVELS (NUM_LEVELS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .stat          (stat),
        .s_cmd         (s_cmd),
        .s_slot_id     (s_slot_id),
        .s_period      (s_period),
        .s_level       (s_level),
        .m_status      (m_status),
        .m_chosen_slot (m_chosen_slot),
        .m_due_map     (m_due_map),
        .m_live_map    (m_live_map),
        .m_longest_run (m_longest_run),
        .m_now_time    (m_now_time)
    );
endmodule

FILE: tb/periodic_task_scheduler_unit_test.sv
`timescale 1ns / 1ps
module periodic_task_scheduler_unit_test;
    import pts_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 360;   // per idling phase

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  chosen_slot;
        logic [MAP_W-1:0] due_map;
        logic [MAP_W-1:0] live_map;
        logic [PER_W-1:0] longest_run;
        logic [PER_W-1:0] now_time;
    } sched_result_t;

    // scheduler predictor plus the queue of results still owed by the block
    class sched_scoreboard;
        sched_result_t    owed[$];
        int               errors;
        int               results;
        int               dispatch_hits;
        int               requests;
        logic [31:0]      now_tick;
        logic [31:0]      periods[SLOTS_DEF];
        logic [31:0]      anchors[SLOTS_DEF];
        logic [31:0]      longest[SLOTS_DEF];
        logic [31:0]      dispatched_at[SLOTS_DEF];
        logic [1:0]       levels[SLOTS_DEF];
        logic [1:0]       run_state[SLOTS_DEF];
        bit               ran_once[SLOTS_DEF];
        logic [MAP_W-1:0] due;
        logic [MAP_W-1:0] live;

        function new();
            now_tick = '0;
            due = '0;
            live = '0;
            for (int i = 0; i < SLOTS_DEF; i++) begin
                periods[i] = '0;
                anchors[i] = '0;
                longest[i] = '0;
                dispatched_at[i] = '0;
                levels[i] = '0;
                run_state[i] = ST_READY;
                ran_once[i] = 1'b0;
            end
        endfunction

        function void note_request(logic [3:0] cmd, logic [3:0] id, logic [31:0] per,
                                   logic [1:0] lvl);
            sched_result_t r;
            int best;
            r = '0;
            requests++;
            if (cmd == CMD_TICK) begin
                now_tick = now_tick + 1;
                for (int i = 0; i < SLOTS_DEF; i++)
                    if (live[i] && run_state[i] == ST_READY && now_tick - anchors[i] >= periods[i])
                        due[i] = 1'b1;
            end else if (cmd == CMD_ADD) begin
                r.status = STAT_NONE;
                for (int i = 0; i < SLOTS_DEF; i++) begin
                    if (!live[i]) begin
                        periods[i] = per;
                        anchors[i] = now_tick;
                        longest[i] = '0;
                        run_state[i] = ST_READY;
                        levels[i] = lvl;
                        live[i] = 1'b1;
                        r.status = STAT_OK;
                        r.chosen_slot = ID_W'(i);
                        break;
                    end
                end
            end else if (cmd == CMD_DISPATCH) begin
                best = -1;
                for (int i = 0; i < SLOTS_DEF; i++)
                    if (due[i] && live[i] && run_state[i] == ST_READY && levels[i] < LEVELS_DEF
                        && (best < 0 || levels[i] < levels[best]))
                        best = i;
                if (best < 0) begin
                    r.status = STAT_NONE;
                end else begin
                    due[best] = 1'b0;
                    run_state[best] = ST_RUNNING;
                    dispatched_at[best] = now_tick;
                    ran_once[best] = 1'b1;
                    r.chosen_slot = ID_W'(best);
                    dispatch_hits++;
                end
            end else if (cmd >= CMD_REMOVE && cmd <= CMD_COMPLETE) begin
                if (id >= SLOTS_DEF) begin
                    r.status = STAT_RANGE;
                end else begin
                    case (cmd)
                        CMD_REMOVE: begin
                            live[id] = 1'b0;
                            due[id] = 1'b0;
                            run_state[id] = ST_SUSPENDED;
                        end
                        CMD_SUSPEND: begin
                            run_state[id] = ST_SUSPENDED;
                            due[id] = 1'b0;
                        end
                        CMD_RESUME: begin
                            run_state[id] = ST_READY;
                            anchors[id] = now_tick;
                        end
                        CMD_SET_PER: begin
                            periods[id] = per;
                            anchors[id] = now_tick;
                        end
                        CMD_SET_PRI: levels[id] = lvl;
                        default: begin
                            if (now_tick - dispatched_at[id] > longest[id])
                                longest[id] = now_tick - dispatched_at[id];
                            anchors[id] = now_tick;
                            run_state[id] = ST_READY;
                            r.longest_run = longest[id];
                        end
                    endcase
                end
            end
            r.due_map = due;
            r.live_map = live;
            r.now_time = now_tick;
            owed.push_back(r);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t w;
            results++;
            if (owed.size() == 0) begin
                $error("result with nothing owed: %p", got);
                errors++;
                return;
            end
            w = owed.pop_front();
            if (got.status !== w.status) begin
                $error("status: expected %0d got %0d", w.status, got.status);
                errors++;
            end
            if (got.chosen_slot !== w.chosen_slot) begin
                $error("chosen_slot: expected %0d got %0d", w.chosen_slot, got.chosen_slot);
                errors++;
            end
            if (got.due_map !== w.due_map) begin
                $error("due_map: expected %h got %h", w.due_map, got.due_map);
                errors++;
            end
            if (got.live_map !== w.live_map) begin
                $error("live_map: expected %h got %h", w.live_map, got.live_map);
                errors++;
            end
            if (got.longest_run !== w.longest_run) begin
                $error("longest_run: expected %0d got %0d", w.longest_run, got.longest_run);
                errors++;
            end
            if (got.now_time !== w.now_time) begin
                $error("now_time: expected %0d got %0d", w.now_time, got.now_time);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [3:0]        s_cmd = '0;
    logic [ID_W-1:0]   s_slot_id = '0;
    logic [PER_W-1:0]  s_period = '0;
    logic [LVL_W-1:0]  s_level = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic [ID_W-1:0]   m_chosen_slot;
    logic [MAP_W-1:0]  m_due_map;
    logic [MAP_W-1:0]  m_live_map;
    logic [PER_W-1:0]  m_longest_run;
    logic [PER_W-1:0]  m_now_time;

    sched_scoreboard sb = new();
    int send_idle_pct = 10;   // chance per cycle that the sender holds back
    int recv_idle_pct = 50;   // chance per cycle that the receiver stalls
    int recv_hold     = 0;    // long receiver hold-off, counted down below
    int cycles        = 0;

    periodic_task_scheduler_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_slot_id(s_slot_id),
        .s_period(s_period), .s_level(s_level),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_chosen_slot(m_chosen_slot), .m_due_map(m_due_map), .m_live_map(m_live_map),
        .m_longest_run(m_longest_run), .m_now_time(m_now_time)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // watchdog, counts every clock from time zero
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results owed", cycles, sb.owed.size());
            $display("status: fail");
            $finish;
        end
    end

    // result side: check at the edge where a result is taken, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_status, m_chosen_slot, m_due_map, m_live_map,
                             m_longest_run, m_now_time});
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one request: idle gaps first, then hold valid until the block takes it
    task automatic send_request(logic [3:0] cmd, logic [3:0] id, logic [31:0] per,
                                logic [1:0] lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_slot_id <= id;
        s_period  <= per;
        s_level   <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(cmd, id, per, lvl);
    endtask

    // stop offering and wait until every owed result is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // mostly well-formed traffic: ticks, dispatch, complete of running tasks
    task automatic send_random();
        logic [3:0]  cmd;
        logic [3:0]  id;
        logic [31:0] per;
        logic [1:0]  lvl;
        int          r;
        r   = $urandom_range(99);
        id  = 4'($urandom_range(SLOTS_DEF - 1));
        per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(6);
        lvl = 2'($urandom_range(3));
        if (r < 35)      cmd = CMD_TICK;
        else if (r < 50) cmd = CMD_DISPATCH;
        else if (r < 62) begin
            cmd = CMD_COMPLETE;
            // favor a running slot when one exists
            for (int i = 0; i < SLOTS_DEF; i++)
                if (sb.run_state[i] == ST_RUNNING && $urandom_range(1)) id = 4'(i);
        end
        else if (r < 72) cmd = CMD_ADD;
        else if (r < 76) cmd = CMD_REMOVE;
        else if (r < 80) cmd = CMD_SUSPEND;
        else if (r < 84) cmd = CMD_RESUME;
        else if (r < 88) cmd = CMD_SET_PER;
        else if (r < 92) cmd = CMD_SET_PRI;
        else if (r < 97) begin
            cmd = 4'($urandom_range(CMD_REMOVE, CMD_COMPLETE));
            id  = 4'($urandom_range(SLOTS_DEF, 15));
        end else begin
            cmd = 4'($urandom_range(9, 15));
            id  = 4'($urandom_range(15));
        end
        // a slot never dispatched has no run start to measure from
        if (cmd == CMD_COMPLETE && id < SLOTS_DEF && !sb.ran_once[id])
            id = 4'($urandom_range(SLOTS_DEF, 15));
        send_request(cmd, id, per, lvl);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, each command, rejects, full table, nothing due
        send_request(CMD_DISPATCH, 4'd0, 32'd0, 2'd0);           // nothing due
        send_request(CMD_ADD, 4'd0, 32'd0, 2'd3);
        send_request(CMD_ADD, 4'd0, 32'hFFFF_FFFF, 2'd0);
        send_request(CMD_TICK, 4'd0, 32'd0, 2'd0);
        send_request(CMD_DISPATCH, 4'd0, 32'd0, 2'd0);
        send_request(CMD_TICK, 4'd0, 32'd0, 2'd0);
        send_request(CMD_COMPLETE, 4'd0, 32'd0, 2'd0);
        send_request(CMD_REMOVE, 4'd15, 32'd0, 2'd0);            // out of range
        send_request(CMD_COMPLETE, 4'd10, 32'd0, 2'd0);          // out of range
        send_request(CMD_SUSPEND, 4'd1, 32'd0, 2'd0);
        send_request(CMD_RESUME, 4'd1, 32'd0, 2'd0);
        send_request(CMD_SET_PER, 4'd1, 32'd2, 2'd0);
        send_request(CMD_SET_PRI, 4'd1, 32'd0, 2'd3);
        send_request(4'd9, 4'd3, 32'hFFFF_FFFF, 2'd3);           // unknown codes
        send_request(4'd15, 4'd15, 32'd0, 2'd0);
        send_request(CMD_SET_PER, 4'd9, 32'd1, 2'd0);            // free slot fields
        send_request(CMD_SUSPEND, 4'd9, 32'd0, 2'd0);
        for (int i = 0; i < 8; i++)
            send_request(CMD_ADD, 4'd0, i, i[1:0]);
        send_request(CMD_ADD, 4'd0, 32'd1, 2'd1);                // table full
        send_request(CMD_TICK, 4'd0, 32'd0, 2'd0);
        send_request(CMD_TICK, 4'd0, 32'd0, 2'd0);
        send_request(CMD_DISPATCH, 4'd0, 32'd0, 2'd0);
        drain();

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_hold = 400;
        repeat (20) send_random();
        drain();

        // idling phases: sender light / receiver heavy, swapped, then none
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 10 : (p == 1) ? 50 : 0;
            recv_idle_pct = (p == 0) ? 50 : (p == 1) ? 10 : 0;
            repeat (RAND_ITEMS) send_random();
            drain();
        end

        $display("covered %0d requests, %0d results checked, %0d successful dispatches",
                 sb.requests, sb.results, sb.dispatch_hits);
        $display("final clock %0d ticks, live map %h, errors %0d",
                 sb.now_tick, sb.live, sb.errors);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
rtl/pts_pkg.sv
rtl/pts_ctrl.sv
rtl/pts_dp.sv
rtl/periodic_task_scheduler_unit.sv
tb/periodic_task_scheduler_unit_test.sv
